@@ hw/rtl/cc20_pkg.sv @@
// shared types, constants and helper functions for the chacha20 stream cipher core
// no dependencies; imported by every module of the block
package cc20_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned WordsN = 16;
  localparam int unsigned AddrW  = $clog2(WordsN);
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned PosW = 6;

  localparam logic [3:0] LastDoubleRound = 4'd9;
  localparam logic [2:0] LastQuarter     = 3'd7;

  // register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] CfgKeyPart0    = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgKeyPart1    = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgKeyPart2    = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgKeyPart3    = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgNonceLower  = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgNonceUpper  = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgInitCounter = 3'd6;

  // "expand 32-byte k"
  localparam logic [3:0][WordW-1:0] Sigma = {
    32'h6b206574, 32'h79622d32, 32'h3320646e, 32'h61707865
  };

  typedef logic [7:0][WordW-1:0] key_t;
  typedef logic [2:0][WordW-1:0] nonce_t;

  typedef struct packed {
    logic             en;
    logic [AddrW-1:0] addr;
    logic [WordW-1:0] data;
  } ram_wr_t;

  typedef enum logic [2:0] {
    ENG_IDLE,
    ENG_INIT,
    ENG_READ,
    ENG_OP,
    ENG_WRITE,
    ENG_FEED
  } eng_state_e;

  typedef enum logic [1:0] {
    TOP_IDLE,
    TOP_BLOCK,
    TOP_KSRD,
    TOP_USE
  } top_state_e;

  // word idx of the block input state
  function automatic logic [WordW-1:0] init_word(logic [AddrW-1:0] idx, key_t key,
                                                 logic [WordW-1:0] ctr, nonce_t nonce);
    logic [WordW-1:0] w;
    case (idx[3:2])
      2'd0: w = Sigma[idx[1:0]];
      2'd1: w = key[{1'b0, idx[1:0]}];
      2'd2: w = key[{1'b1, idx[1:0]}];
      2'd3: w = (idx[1:0] == 2'd0) ? ctr : nonce[idx[1:0] - 2'd1];
      default: w = '0;
    endcase
    return w;
  endfunction

  // word address of operand j (a, b, c, d) of quarter round qsel within a double round
  function automatic logic [AddrW-1:0] qr_addr(logic [2:0] qsel, logic [1:0] j);
    logic [1:0] col;
    col = qsel[1:0] + (qsel[2] ? j : 2'd0);
    return {j, col};
  endfunction

endpackage

@@ hw/rtl/cc20_ram.sv @@
// 16 x 32 word memory, one write port and one read port, registered read data
// uses cc20_pkg for widths
module cc20_ram (
  input  logic                        clk_i,
  input  cc20_pkg::ram_wr_t           wr_i,
  input  logic [cc20_pkg::AddrW-1:0]  rd_addr_i,
  output logic [cc20_pkg::WordW-1:0]  rd_data_o
);
  import cc20_pkg::*;

  logic [WordW-1:0] mem_q [WordsN];
  logic [WordW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ hw/rtl/cc20_block_engine.sv @@
// keystream block sequencer: loads the working words, runs 80 quarter rounds one
// operand access at a time through the working memory, then adds the feed-forward
// depends on cc20_pkg and cc20_ram
module cc20_block_engine (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  cc20_pkg::key_t              key_i,
  input  cc20_pkg::nonce_t            nonce_i,
  input  logic [cc20_pkg::WordW-1:0]  counter_i,
  output logic                        done_o,
  output cc20_pkg::ram_wr_t           ks_wr_o
);
  import cc20_pkg::*;

  eng_state_e       state_q, state_d;
  logic [4:0]       cnt_q;
  logic [3:0]       dr_q;
  logic [2:0]       qsel_q;
  logic [WordW-1:0] w_q [4];

  ram_wr_t          wk_wr;
  logic [AddrW-1:0] wk_rd_addr;
  logic [WordW-1:0] wk_rd_data;
  logic             rd_active;

  logic [WordW-1:0] op_sum, op_mix;
  logic [AddrW-1:0] ff_addr;

  cc20_ram u_work_ram (
    .clk_i     (clk_i),
    .wr_i      (wk_wr),
    .rd_addr_i (wk_rd_addr),
    .rd_data_o (wk_rd_data)
  );

  assign ff_addr = cnt_q[3:0] - 4'd1;

  // one add, xor and rotate of the quarter round per step
  always_comb begin
    op_sum = '0;
    op_mix = '0;
    case (cnt_q[1:0])
      2'd0: begin
        op_sum = w_q[0] + w_q[1];
        op_mix = w_q[3] ^ op_sum;
        op_mix = {op_mix[15:0], op_mix[31:16]};
      end
      2'd1: begin
        op_sum = w_q[2] + w_q[3];
        op_mix = w_q[1] ^ op_sum;
        op_mix = {op_mix[19:0], op_mix[31:20]};
      end
      2'd2: begin
        op_sum = w_q[0] + w_q[1];
        op_mix = w_q[3] ^ op_sum;
        op_mix = {op_mix[23:0], op_mix[31:24]};
      end
      2'd3: begin
        op_sum = w_q[2] + w_q[3];
        op_mix = w_q[1] ^ op_sum;
        op_mix = {op_mix[24:0], op_mix[31:25]};
      end
      default: begin
        op_sum = '0;
        op_mix = '0;
      end
    endcase
  end

  always_comb begin
    state_d    = state_q;
    wk_wr      = '0;
    wk_rd_addr = '0;
    rd_active  = 1'b0;
    ks_wr_o    = '0;
    done_o     = 1'b0;
    case (state_q)
      ENG_IDLE: begin
        if (start_i) begin
          state_d = ENG_INIT;
        end
      end
      ENG_INIT: begin
        wk_wr.en   = 1'b1;
        wk_wr.addr = cnt_q[3:0];
        wk_wr.data = init_word(cnt_q[3:0], key_i, counter_i, nonce_i);
        if (cnt_q[3:0] == 4'd15) begin
          state_d = ENG_READ;
        end
      end
      ENG_READ: begin
        rd_active  = (cnt_q < 5'd4);
        wk_rd_addr = qr_addr(qsel_q, cnt_q[1:0]);
        if (cnt_q == 5'd4) begin
          state_d = ENG_OP;
        end
      end
      ENG_OP: begin
        if (cnt_q[1:0] == 2'd3) begin
          state_d = ENG_WRITE;
        end
      end
      ENG_WRITE: begin
        wk_wr.en   = 1'b1;
        wk_wr.addr = qr_addr(qsel_q, cnt_q[1:0]);
        wk_wr.data = w_q[cnt_q[1:0]];
        if (cnt_q[1:0] == 2'd3) begin
          if (qsel_q == LastQuarter && dr_q == LastDoubleRound) begin
            state_d = ENG_FEED;
          end else begin
            state_d = ENG_READ;
          end
        end
      end
      ENG_FEED: begin
        rd_active  = (cnt_q < 5'd16);
        wk_rd_addr = cnt_q[3:0];
        if (cnt_q != 5'd0) begin
          ks_wr_o.en   = 1'b1;
          ks_wr_o.addr = ff_addr;
          ks_wr_o.data = wk_rd_data + init_word(ff_addr, key_i, counter_i, nonce_i);
        end
        if (cnt_q == 5'd16) begin
          done_o  = 1'b1;
          state_d = ENG_IDLE;
        end
      end
      default: state_d = ENG_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ENG_IDLE;
      cnt_q   <= '0;
      dr_q    <= '0;
      qsel_q  <= '0;
    end else begin
      state_q <= state_d;
      if (state_d != state_q) begin
        cnt_q <= '0;
      end else if (state_q != ENG_IDLE) begin
        cnt_q <= cnt_q + 5'd1;
      end
      if (state_q == ENG_INIT) begin
        dr_q   <= '0;
        qsel_q <= '0;
      end else if (state_q == ENG_WRITE && cnt_q[1:0] == 2'd3) begin
        qsel_q <= qsel_q + 3'd1;
        // the round count stays on the last double round once the rounds are done
        if (qsel_q == LastQuarter && dr_q != LastDoubleRound) begin
          dr_q <= dr_q + 4'd1;
        end
      end
    end
  end

  // operand registers: loaded from the registered memory read data, then updated by each operation step
  always_ff @(posedge clk_i) begin
    if (state_q == ENG_READ && cnt_q != 5'd0) begin
      w_q[cnt_q[1:0] - 2'd1] <= wk_rd_data;
    end else if (state_q == ENG_OP) begin
      if (cnt_q[0]) begin
        w_q[2] <= op_sum;
        w_q[1] <= op_mix;
      end else begin
        w_q[0] <= op_sum;
        w_q[3] <= op_mix;
      end
    end
  end

  a_start_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> state_q == ENG_IDLE)
    else $error("block start while engine busy");

  a_no_rw_overlap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(wk_wr.en && rd_active))
    else $error("working memory read and write in the same cycle");

  a_round_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    dr_q <= LastDoubleRound)
    else $error("double round count out of range");

  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> state_q == ENG_IDLE && !ks_wr_o.en)
    else $error("engine active after done");

endmodule

@@ hw/rtl/chacha20_stream_cipher_core.sv @@
// chacha20 stream cipher top level: configuration registers, byte path, keystream memory
// depends on cc20_pkg, cc20_ram and cc20_block_engine
//
//   channel  direction  handshake                   payload
//   in       input      in_valid_i / in_stall_o     data_byte_i, last_byte_i
//   out      output     out_valid_o / out_stall_i   result_byte_o, last_out_o, next_counter_o
//   cfg      input      cfg_valid_i / cfg_ready_o   cfg_index_i, cfg_data_i
//
// a byte inside a keystream block passes from the idle state to the use state, where its
//   result is registered; the input takes no new byte until the core is back in idle
// the first byte of each block waits in the block state while the engine loads the words,
//   runs 80 quarter rounds (reading four operands, four operation steps, four write-backs)
//   and adds the feed-forward; it then passes through the keystream read and use states
// reset clears control and config registers and message position; memories need no clearing
// the input is stalled while a word is in progress or the output holds an untaken word
module chacha20_stream_cipher_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    data_byte_i,
  input  logic                          last_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [7:0]                    result_byte_o,
  output logic                          last_out_o,
  output logic [31:0]                   next_counter_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [cc20_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [cc20_pkg::CfgDataW-1:0] cfg_data_i
);
  import cc20_pkg::*;

  top_state_e       state_q, state_d;
  key_t             key_q;
  nonce_t           nonce_q;
  logic [WordW-1:0] init_ctr_q;
  logic [WordW-1:0] ctr_q;
  logic [PosW-1:0]  pos_q;
  logic             in_msg_q;
  logic [7:0]       data_q;
  logic             last_q;

  logic             out_valid_q;
  logic [7:0]       result_q;
  logic             last_out_q;
  logic [WordW-1:0] next_ctr_q;

  logic             in_accept;
  logic [PosW-1:0]  pos_eff;
  logic             eng_start;
  logic             eng_done;
  ram_wr_t          ks_wr;
  logic [AddrW-1:0] ks_rd_addr;
  logic [WordW-1:0] ks_rd_data;
  logic [7:0]       ks_byte;

  assign cfg_ready_o = 1'b1;

  assign in_stall_o = !(state_q == TOP_IDLE && (!out_valid_q || !out_stall_i));
  assign in_accept  = in_valid_i && !in_stall_o;
  assign pos_eff    = in_msg_q ? pos_q : '0;
  assign eng_start  = in_accept && (pos_eff == '0);
  assign ks_rd_addr = (state_q == TOP_IDLE) ? pos_eff[5:2] : pos_q[5:2];
  assign ks_byte    = ks_rd_data[{pos_q[1:0], 3'b000} +: 8];

  cc20_block_engine u_engine (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (eng_start),
    .key_i     (key_q),
    .nonce_i   (nonce_q),
    .counter_i (ctr_q),
    .done_o    (eng_done),
    .ks_wr_o   (ks_wr)
  );

  cc20_ram u_ks_ram (
    .clk_i     (clk_i),
    .wr_i      (ks_wr),
    .rd_addr_i (ks_rd_addr),
    .rd_data_o (ks_rd_data)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      TOP_IDLE: begin
        if (in_accept) begin
          state_d = eng_start ? TOP_BLOCK : TOP_USE;
        end
      end
      TOP_BLOCK: begin
        if (eng_done) begin
          state_d = TOP_KSRD;
        end
      end
      TOP_KSRD: state_d = TOP_USE;
      TOP_USE:  state_d = TOP_IDLE;
      default:  state_d = TOP_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= TOP_IDLE;
      key_q       <= '0;
      nonce_q     <= '0;
      init_ctr_q  <= '0;
      ctr_q       <= '0;
      pos_q       <= '0;
      in_msg_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CfgKeyPart0:    key_q[1:0] <= cfg_data_i;
          CfgKeyPart1:    key_q[3:2] <= cfg_data_i;
          CfgKeyPart2:    key_q[5:4] <= cfg_data_i;
          CfgKeyPart3:    key_q[7:6] <= cfg_data_i;
          CfgNonceLower:  nonce_q[1:0] <= cfg_data_i;
          CfgNonceUpper:  nonce_q[2] <= cfg_data_i[31:0];
          CfgInitCounter: init_ctr_q <= cfg_data_i[31:0];
          default: ;
        endcase
      end
      // message start reloads the counter before the block is computed
      if (in_accept && !in_msg_q) begin
        ctr_q    <= init_ctr_q;
        pos_q    <= '0;
        in_msg_q <= 1'b1;
      end
      if (state_q == TOP_USE) begin
        if (last_q) begin
          pos_q    <= '0;
          in_msg_q <= 1'b0;
        end else begin
          pos_q <= pos_q + 6'd1;
          if (pos_q == '1) begin
            ctr_q <= ctr_q + 32'd1;
          end
        end
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      data_q <= data_byte_i;
      last_q <= last_byte_i;
    end
    if (state_q == TOP_USE) begin
      result_q   <= data_q ^ ks_byte;
      last_out_q <= last_q;
      next_ctr_q <= last_q ? ctr_q + 32'd1 : '0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_byte_o  = result_q;
  assign last_out_o     = last_out_q;
  assign next_counter_o = next_ctr_q;

endmodule

@@ bench/chacha20_stream_cipher_core_tb.sv @@
`timescale 1ns / 1ps
// self-checking bench for chacha20_stream_cipher_core: bytes in, keystream xor out
// depends on cc20_pkg for register indexes and the sigma words

module chacha20_stream_cipher_core_tb;

  import cc20_pkg::*;

  localparam int DoubleRounds = 10;
  localparam int TargetItems  = 650;

  typedef struct packed {
    logic [7:0]  ct_byte;
    logic        last;
    logic [31:0] next_ctr;
  } cipher_word_t;

  class cipher_scoreboard;
    bit [63:0]    key_part [4];
    bit [63:0]    nonce_lo;
    bit [31:0]    nonce_hi;
    bit [31:0]    start_ctr;
    bit [31:0]    blk_ctr;
    bit [5:0]     pos;
    bit           in_msg;
    bit [31:0]    keystream [16];
    bit [31:0]    work [16];
    cipher_word_t expected_out [$];
    int           errors;

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
      case (idx)
        CfgKeyPart0:    key_part[0] = val;
        CfgKeyPart1:    key_part[1] = val;
        CfgKeyPart2:    key_part[2] = val;
        CfgKeyPart3:    key_part[3] = val;
        CfgNonceLower:  nonce_lo    = val;
        CfgNonceUpper:  nonce_hi    = val[31:0];
        CfgInitCounter: start_ctr   = val[31:0];
        default: ;
      endcase
    endfunction

    function bit [31:0] rotl(bit [31:0] v, int n);
      return (v << n) | (v >> (32 - n));
    endfunction

    function void quarter(int a, int b, int c, int d);
      work[a] += work[b]; work[d] = rotl(work[d] ^ work[a], 16);
      work[c] += work[d]; work[b] = rotl(work[b] ^ work[c], 12);
      work[a] += work[b]; work[d] = rotl(work[d] ^ work[a], 8);
      work[c] += work[d]; work[b] = rotl(work[b] ^ work[c], 7);
    endfunction

    function void make_keystream();
      bit [31:0] init [16];
      int i;
      for (i = 0; i < 4; i++) begin
        init[i]         = Sigma[i];
        init[4 + 2 * i] = key_part[i][31:0];
        init[5 + 2 * i] = key_part[i][63:32];
      end
      init[12] = blk_ctr;
      init[13] = nonce_lo[31:0];
      init[14] = nonce_lo[63:32];
      init[15] = nonce_hi;
      work = init;
      for (i = 0; i < DoubleRounds; i++) begin
        quarter(0, 4, 8, 12);
        quarter(1, 5, 9, 13);
        quarter(2, 6, 10, 14);
        quarter(3, 7, 11, 15);
        quarter(0, 5, 10, 15);
        quarter(1, 6, 11, 12);
        quarter(2, 7, 8, 13);
        quarter(3, 4, 9, 14);
      end
      for (i = 0; i < 16; i++) keystream[i] = work[i] + init[i];
    endfunction

    function void note_plain_word(logic [7:0] d, logic l);
      cipher_word_t exp;
      bit [31:0]    used_ctr;
      bit [31:0]    ks_word;
      if (!in_msg) begin
        blk_ctr = start_ctr;
        pos     = '0;
        in_msg  = 1'b1;
      end
      if (pos == 0) make_keystream();
      ks_word      = keystream[pos[5:2]] >> (8 * pos[1:0]);
      used_ctr     = blk_ctr;
      pos          = pos + 6'd1;
      if (pos == 0) blk_ctr = blk_ctr + 32'd1;
      exp.ct_byte  = d ^ ks_word[7:0];
      exp.last     = l;
      // a partial final block still counts as a whole block
      exp.next_ctr = l ? used_ctr + 32'd1 : 32'd0;
      expected_out.push_back(exp);
      if (l) begin
        in_msg  = 1'b0;
        pos     = '0;
        blk_ctr = start_ctr;
      end
    endfunction

    function void check_cipher_word(logic [7:0] b, logic l, logic [31:0] c);
      cipher_word_t exp;
      if (expected_out.size() == 0) begin
        $display("%0t: unexpected word: result_byte %02h last_out %0b next_counter %08h",
                 $time, b, l, c);
        errors++;
        return;
      end
      exp = expected_out.pop_front();
      if (exp.ct_byte !== b) begin
        $display("%0t: result_byte expected %02h actual %02h", $time, exp.ct_byte, b);
        errors++;
      end
      if (exp.last !== l) begin
        $display("%0t: last_out expected %0b actual %0b", $time, exp.last, l);
        errors++;
      end
      if (exp.next_ctr !== c) begin
        $display("%0t: next_counter expected %08h actual %08h", $time, exp.next_ctr, c);
        errors++;
      end
    endfunction

    function int pending();
      return expected_out.size();
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [7:0]          data_byte_i;
  logic                last_byte_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [7:0]          result_byte_o;
  logic                last_out_o;
  logic [31:0]         next_counter_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  cipher_scoreboard sb;
  int unsigned      rx_hold_len;
  bit               rx_hold_done;
  int               items_sent;

  chacha20_stream_cipher_core dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #40_000_000;
    $display("FAIL chacha20_stream_cipher_core");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) sb.set_reg(cfg_index_i, cfg_data_i);
      if (in_valid_i && !in_stall_o) sb.note_plain_word(data_byte_i, last_byte_i);
      if (out_valid_o && !out_stall_i)
        sb.check_cipher_word(result_byte_o, last_out_o, next_counter_o);
    end
  end

  // receiver: random stalls, clear stretches, and a long hold-off on request
  initial begin
    int unsigned r, n, k;
    out_stall_i = 1'b0;
    @(posedge clk_i);
    forever begin
      if (rx_hold_len != 0) begin
        n           = rx_hold_len;
        rx_hold_len = 0;
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 45) begin
          out_stall_i <= 1'b0;
          n = $urandom_range(1, 30);
        end else if (r < 85) begin
          out_stall_i <= 1'b1;
          n = $urandom_range(1, 3);
        end else if (r < 95) begin
          out_stall_i <= 1'b0;
          n = $urandom_range(50, 150);
        end else begin
          out_stall_i <= 1'b1;
          n = $urandom_range(20, 60);
        end
        for (k = 0; k < n && rx_hold_len == 0; k++) @(posedge clk_i);
      end
    end
  end

  // valid stays high after the write so back-to-back writes need no toggle
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic send_byte(input logic [7:0] d, input logic l, input int unsigned gap);
    in_valid_i  <= 1'b1;
    data_byte_i <= d;
    last_byte_i <= l;
    do @(posedge clk_i); while (in_stall_o);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_idle();
    in_valid_i  <= 1'b0;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic send_message(input int unsigned len);
    int unsigned gap, r, k;
    bit          steady;
    steady = ($urandom_range(0, 3) == 0);
    for (k = 0; k < len; k++) begin
      gap = 0;
      if (!steady) begin
        r = $urandom_range(0, 99);
        if (r < 30) gap = $urandom_range(1, 3);
        else if (r < 38) gap = $urandom_range(4, 12);
        else if (r < 40) gap = $urandom_range(20, 40);
      end
      // block the receiver mid-message so the core backs up into its input
      if (k == 1 && !rx_hold_done && len >= 20 && items_sent >= 250) begin
        rx_hold_len  = 400;
        rx_hold_done = 1'b1;
      end
      send_byte(8'($urandom_range(0, 255)), k == len - 1, gap);
      items_sent++;
    end
  endtask

  task automatic shuffle_config(input bit wrap_counter);
    logic [CfgDataW-1:0] val;
    int unsigned         r;
    int                  i;
    for (i = 0; i < 8; i++) begin
      if ($urandom_range(0, 2) == 0 || (wrap_counter && i == CfgInitCounter)) begin
        r   = $urandom_range(0, 9);
        val = {$urandom, $urandom};
        if (r == 0) val = '0;
        if (r == 1) val = '1;
        if (i == CfgInitCounter && r == 2) val = 64'hFFFF_FFFE;
        if (wrap_counter && i == CfgInitCounter) val = '1;
        write_reg(CfgIdxW'(i), val);
      end
    end
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    int          i, n;
    int unsigned r, len;
    sb           = new;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    data_byte_i  = '0;
    last_byte_i  = 1'b0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = '0;
    cfg_data_i   = '0;
    rx_hold_len  = 0;
    rx_hold_done = 1'b0;
    items_sent   = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // all-zero key, nonce and counter straight out of reset
    send_byte(8'h00, 1'b1, 0);
    wait_idle();

    // every register all ones, counter wraps to zero at the end
    for (i = 0; i < 8; i++) write_reg(CfgIdxW'(i), '1);
    cfg_valid_i <= 1'b0;
    send_byte(8'hFF, 1'b0, 0);
    send_byte(8'h00, 1'b0, 2);
    send_byte(8'hA5, 1'b1, 0);
    wait_idle();

    // known-answer key and nonce, counter 1
    write_reg(CfgKeyPart0, 64'h0706_0504_0302_0100);
    write_reg(CfgKeyPart1, 64'h0F0E_0D0C_0B0A_0908);
    write_reg(CfgKeyPart2, 64'h1716_1514_1312_1110);
    write_reg(CfgKeyPart3, 64'h1F1E_1D1C_1B1A_1918);
    write_reg(CfgNonceLower, 64'h4A00_0000_0900_0000);
    write_reg(CfgNonceUpper, 64'h0);
    write_reg(CfgInitCounter, 64'h1);
    cfg_valid_i <= 1'b0;
    for (i = 0; i < 16; i++) send_byte(8'h00, i == 15, 0);
    send_byte(8'hFF, 1'b1, 1);
    wait_idle();

    // counter wrap inside a multi-block message
    shuffle_config(1'b1);
    send_message(130);

    while (items_sent < TargetItems) begin
      wait_idle();
      shuffle_config(1'b0);
      n = $urandom_range(1, 4);
      repeat (n) begin
        r = $urandom_range(0, 9);
        if (r < 6) len = $urandom_range(1, 12);
        else if (r < 8) len = $urandom_range(13, 40);
        else if (r < 9) len = $urandom_range(60, 68);
        else len = $urandom_range(120, 135);
        if (items_sent < TargetItems) send_message(len);
      end
    end

    wait_idle();
    repeat (50) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS chacha20_stream_cipher_core");
    end else begin
      $display("FAIL chacha20_stream_cipher_core");
    end
    $finish;
  end

endmodule

@@ chacha20_stream_cipher_core.f @@
hw/rtl/cc20_pkg.sv
hw/rtl/cc20_ram.sv
hw/rtl/cc20_block_engine.sv
hw/rtl/chacha20_stream_cipher_core.sv
bench/chacha20_stream_cipher_core_tb.sv
